// ===== rtl/wait_slot_release_table_unit_defines.svh =====
// Assertion macros shared by the wait slot release table RTL.
// Expects clk and rst_n in the scope of use.
`ifndef WAIT_SLOT_RELEASE_TABLE_UNIT_DEFINES_SVH
`define WAIT_SLOT_RELEASE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define WSRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WSRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsrt_pkg.sv =====
// Package for the wait slot release table: word types, request token
// handed along the slot chain, and request/status/slot-state codes.
package wsrt_pkg;

    localparam int REASON_W = 16;
    localparam int SLOT_W   = 4;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 5;

    // request kinds
    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_REL_ONE = 2'd1;
    localparam logic [1:0] REQ_REL_ALL = 2'd2;
    localparam logic [1:0] REQ_DEPART  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_SLOT = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE   = 2'd1;
    localparam logic [1:0] SLOT_RELEASED = 2'd2;

    // register index
    localparam logic REG_ALL_REASON = 1'b0;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [REASON_W-1:0] reason;
        logic [SLOT_W-1:0]   slot_index;
    } wsrt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot_out;
        logic [MASK_W-1:0]  woken_mask;
        logic               was_released;
        logic [COUNT_W-1:0] active_count;
    } wsrt_out_t;

    // request token passed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic [REASON_W-1:0] reason;
        logic                all_hit;
        logic [SLOT_W-1:0]   idx;
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic                was;
    } wsrt_tok_t;

endpackage

// ===== rtl/wsrt_cell.sv =====
// One waiter slot of the chain: holds slot state and reason, acts on the
// token as it passes and hands it on through its token register. Uses wsrt_pkg.
module wsrt_cell
    import wsrt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int RW    = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  wsrt_tok_t tok_in,
    output wsrt_tok_t tok_out,
    output logic      woken
);

    localparam logic [SLOT_W-1:0] IDX_CODE = SLOT_W'(INDEX);
    localparam bit                IN_RANGE = INDEX < (1 << SLOT_W);

    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [RW-1:0] reason_reg;
    logic [RW-1:0] reason_next;
    logic          woken_reg;
    logic          woken_next;
    wsrt_tok_t     tok_reg;
    wsrt_tok_t     tok_next;
    logic          hit;

    assign hit = (status_reg == SLOT_ACTIVE) &&
                 ((reason_reg == tok_in.reason[RW-1:0]) || tok_in.all_hit);

    always_comb
    begin
        tok_next    = tok_in;
        status_next = status_reg;
        reason_next = reason_reg;
        woken_next  = woken_reg;
        if (tok_in.valid)
        begin
            woken_next = 1'b0;
            case (tok_in.kind)
                REQ_ADD:
                begin
                    if (status_reg == SLOT_FREE && !tok_in.found)
                    begin
                        status_next    = SLOT_ACTIVE;
                        reason_next    = tok_in.reason[RW-1:0];
                        tok_next.found = 1'b1;
                        tok_next.slot  = IDX_CODE;
                    end
                end
                REQ_REL_ONE:
                begin
                    if (hit && !tok_in.found)
                    begin
                        status_next    = SLOT_RELEASED;
                        woken_next     = 1'b1;
                        tok_next.found = 1'b1;
                        tok_next.slot  = IDX_CODE;
                    end
                end
                REQ_REL_ALL:
                begin
                    if (hit)
                    begin
                        status_next = SLOT_RELEASED;
                        woken_next  = 1'b1;
                    end
                end
                REQ_DEPART:
                begin
                    if (IN_RANGE && tok_in.idx == IDX_CODE && status_reg != SLOT_FREE)
                    begin
                        status_next    = SLOT_FREE;
                        tok_next.found = 1'b1;
                        tok_next.was   = (status_reg == SLOT_RELEASED);
                    end
                end
                default:
                begin
                    tok_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= SLOT_FREE;
            woken_reg  <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            status_reg <= status_next;
            woken_reg  <= woken_next;
            tok_reg    <= tok_next;
        end
    end

    // reason is only read while the slot is occupied
    always_ff @(posedge clk)
    begin
        reason_reg <= reason_next;
    end

    assign tok_out = tok_reg;
    assign woken   = woken_reg;

endmodule

// ===== rtl/wait_slot_release_table_unit.sv =====
// Top level of the wait slot release table: input/output words, APB
// register, token head, chain of wsrt_cell slots and result register.
// Uses wsrt_pkg and wait_slot_release_table_unit_defines.svh.
//
//   channel   direction  handshake          payload
//   in        to block   in_valid/in_stall  in_data   (wsrt_in_t)
//   out       from block out_valid/out_stall out_data (wsrt_out_t)
//   config    to block   APB psel/penable   paddr/pwdata/prdata
//
// A word walks the slot chain one cell per cycle: out_valid rises once the word
// has passed the head register, the SLOTS cells and the result register.
// One request is in flight at a time; in_stall is high until the result
// has been taken, so the block takes no new word while one is in flight.
// out_stall holds the result word in its register.
// Reset frees every slot and clears the count; no clearing pass is needed.
`include "wait_slot_release_table_unit_defines.svh"

module wait_slot_release_table_unit
    import wsrt_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int REASON_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  wsrt_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output wsrt_out_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW    = (REASON_BITS >= REASON_W) ? REASON_W : REASON_BITS;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [REASON_W-1:0] RMASK = REASON_W'((64'd1 << RW) - 64'd1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [REASON_W-1:0] all_code_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    wsrt_tok_t           head_reg;
    wsrt_tok_t           head_next;
    wsrt_out_t           out_reg;
    wsrt_out_t           out_next;
    wsrt_tok_t           tok_w [SLOTS+1];
    logic [SLOTS:0]      tok_vld;
    logic [SLOTS-1:0]    woken_w;
    logic [MASK_W-1:0]   mask_w;
    logic                in_accept;
    logic                cfg_write;
    logic [REASON_W-1:0] r_masked;
    wsrt_tok_t           tail;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ALL_REASON) ? {16'd0, all_code_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_code_reg <= 16'hFFFF;
        end
        else if (cfg_write && paddr[2] == REG_ALL_REASON)
        begin
            all_code_reg <= pwdata[REASON_W-1:0];
        end
    end

    // head of the chain
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign r_masked  = in_data.reason & RMASK;

    always_comb
    begin
        head_next         = '0;
        head_next.valid   = in_accept;
        head_next.kind    = in_data.req_type;
        head_next.reason  = r_masked;
        head_next.all_hit = (r_masked == (all_code_reg & RMASK));
        head_next.idx     = in_data.slot_index;
    end

    assign tok_w[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            wsrt_cell #(
                .INDEX (gi),
                .RW    (RW)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_w[gi]),
                .tok_out (tok_w[gi+1]),
                .woken   (woken_w[gi])
            );
        end
        for (gi = 0; gi <= SLOTS; gi++)
        begin : g_vld
            assign tok_vld[gi] = tok_w[gi].valid;
        end
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < SLOTS)
            begin : g_bit
                assign mask_w[gi] = woken_w[gi];
            end
            else
            begin : g_zero
                assign mask_w[gi] = 1'b0;
            end
        end
    endgenerate

    assign tail = tok_w[SLOTS];

    // gather the result when the token leaves the last cell
    always_comb
    begin
        out_next   = '0;
        count_next = count_reg;
        case (tail.kind)
            REQ_ADD:
            begin
                if (tail.found)
                begin
                    out_next.slot_out = tail.slot;
                    count_next        = count_reg + CNT_W'(1);
                end
                else
                begin
                    out_next.status = ST_FULL;
                end
            end
            REQ_REL_ONE:
            begin
                if (tail.found)
                begin
                    out_next.slot_out   = tail.slot;
                    out_next.woken_mask = mask_w;
                end
                else
                begin
                    out_next.status = ST_NONE;
                end
            end
            REQ_REL_ALL:
            begin
                if (count_reg == '0)
                begin
                    out_next.status = ST_NONE;
                end
                else
                begin
                    out_next.woken_mask = mask_w;
                end
            end
            REQ_DEPART:
            begin
                out_next.slot_out = tail.idx;
                if (tail.found)
                begin
                    out_next.was_released = tail.was;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    out_next.status = ST_NO_SLOT;
                end
            end
            default:
            begin
                out_next.status = ST_NONE;
            end
        endcase
        out_next.active_count = COUNT_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (tail.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (tail.valid)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = (state_reg == S_DONE);
    assign out_data  = out_reg;

    `WSRT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(SLOTS), "count above slot total")
    `WSRT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld), "more than one token in chain")
    `WSRT_ASSERT_NEXT(a_accept_head, in_accept, head_reg.valid, "accepted word not at chain head")
    `WSRT_ASSERT_NEXT(a_tail_result, tail.valid, out_valid, "chain result not presented")

endmodule

// ===== tb/wait_slot_release_table_unit_tb.sv =====
// Self-checking testbench for wait_slot_release_table_unit: a directed table,
// then random phases of add/release/depart words, checked by a predictor or fixed rows.
// Depends on wsrt_pkg and the wait_slot_release_table_unit RTL.
module wait_slot_release_table_unit_tb;
    import wsrt_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 96;

    // profiles of the random phases
    localparam int PROF_FILL  = 0;
    localparam int PROF_DRAIN = 1;
    localparam int PROF_MIXED = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rsn;
        logic [3:0]  idx;
        logic        typed;
        logic [1:0]  st;
        logic [3:0]  slot;
        logic [15:0] mask;
        logic        was;
        logic [4:0]  cnt;
    } dir_row_t;

    // all_reason_code is 16'hFFFF throughout this table
    localparam dir_row_t DIRECTED [0:20] = '{
        '{REQ_REL_ONE, 16'h0000, 4'd0,  1'b1, ST_NONE,    4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ALL, 16'h0000, 4'd0,  1'b1, ST_NONE,    4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd0,  1'b1, ST_NO_SLOT, 4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'hFFFF, 4'd15, 1'b1, ST_NO_SLOT, 4'd15, 16'h0000, 1'b0, 5'd0},
        '{REQ_ADD,     16'h0000, 4'd0,  1'b1, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd1},
        '{REQ_ADD,     16'hFFFF, 4'd0,  1'b1, ST_OK,      4'd1,  16'h0000, 1'b0, 5'd2},
        '{REQ_ADD,     16'h1234, 4'd0,  1'b1, ST_OK,      4'd2,  16'h0000, 1'b0, 5'd3},
        '{REQ_ADD,     16'hA5A5, 4'd9,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ONE, 16'h1234, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ONE, 16'h5555, 4'd0,  1'b1, ST_NONE,    4'd0,  16'h0000, 1'b0, 5'd4},
        '{REQ_REL_ONE, 16'hFFFF, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ALL, 16'h7777, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ALL, 16'hFFFF, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd2,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd2,  1'b1, ST_NO_SLOT, 4'd2,  16'h0000, 1'b0, 5'd3},
        '{REQ_DEPART,  16'h0000, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_ADD,     16'h8000, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd1,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd3,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_DEPART,  16'h0000, 4'd0,  1'b0, ST_OK,      4'd0,  16'h0000, 1'b0, 5'd0},
        '{REQ_REL_ALL, 16'h1234, 4'd0,  1'b1, ST_NONE,    4'd0,  16'h0000, 1'b0, 5'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    wsrt_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    wsrt_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // table model
    logic [1:0]  wait_state [NUM_SLOTS];
    logic [15:0] wait_reason [NUM_SLOTS];
    logic [4:0]  occupied;
    logic [15:0] wake_all_code;

    wsrt_out_t   awaited_results [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    logic [15:0] reason_pool [4];

    wait_slot_release_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic bit wakes(int i, logic [15:0] r);
        return wait_state[i] == SLOT_ACTIVE && (wait_reason[i] == r || r == wake_all_code);
    endfunction

    // Apply one request to the table model and return the result word.
    function automatic wsrt_out_t table_step(wsrt_in_t req);
        wsrt_out_t res;
        bit        done;
        res  = '0;
        done = 1'b0;
        case (req.req_type)
            REQ_ADD:
            begin
                res.status = ST_FULL;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (!done && wait_state[i] == SLOT_FREE)
                    begin
                        wait_state[i]  = SLOT_ACTIVE;
                        wait_reason[i] = req.reason;
                        occupied       = occupied + 5'd1;
                        res.status     = ST_OK;
                        res.slot_out   = 4'(i);
                        done           = 1'b1;
                    end
            end
            REQ_REL_ONE:
            begin
                res.status = ST_NONE;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (!done && wakes(i, req.reason))
                    begin
                        wait_state[i]     = SLOT_RELEASED;
                        res.status        = ST_OK;
                        res.slot_out      = 4'(i);
                        res.woken_mask[i] = 1'b1;
                        done              = 1'b1;
                    end
            end
            REQ_REL_ALL:
            begin
                // any waiter makes this a success, even with nothing woken
                if (occupied == 5'd0)
                    res.status = ST_NONE;
                else
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (wakes(i, req.reason))
                        begin
                            wait_state[i]     = SLOT_RELEASED;
                            res.woken_mask[i] = 1'b1;
                        end
            end
            default:
            begin
                res.slot_out = req.slot_index;
                if (wait_state[req.slot_index] == SLOT_FREE)
                    res.status = ST_NO_SLOT;
                else
                begin
                    res.was_released = wait_state[req.slot_index] == SLOT_RELEASED;
                    wait_state[req.slot_index] = SLOT_FREE;
                    if (occupied != 5'd0)
                        occupied = occupied - 5'd1;
                end
            end
        endcase
        res.active_count = occupied;
        return res;
    endfunction

    // Hold the word until accepted, then queue its expected result.
    task automatic send_word(wsrt_in_t w, bit typed, wsrt_out_t fixed);
        wsrt_out_t res;
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (in_stall);
        res = table_step(w);
        awaited_results.push_back(typed ? fixed : res);
        @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        wake_all_code = data[15:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] pick_reason();
        case ($urandom_range(0, 9))
            6: return wake_all_code;
            7: return 16'h0000;
            8: return 16'hFFFF;
            9: return 16'($urandom);
            default: return reason_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic wsrt_in_t random_word(int profile);
        wsrt_in_t w;
        int       roll;
        int       j;
        w.reason     = pick_reason();
        w.slot_index = 4'($urandom_range(0, NUM_SLOTS - 1));
        roll = $urandom_range(0, 99);
        case (profile)
            PROF_FILL:  w.req_type = roll < 60 ? REQ_ADD : roll < 75 ? REQ_REL_ONE :
                                     roll < 85 ? REQ_REL_ALL : REQ_DEPART;
            PROF_DRAIN: w.req_type = roll < 15 ? REQ_ADD : roll < 40 ? REQ_REL_ONE :
                                     roll < 55 ? REQ_REL_ALL : REQ_DEPART;
            default:    w.req_type = 2'(roll % 4);
        endcase
        // aim most departures at an occupied slot
        if (w.req_type == REQ_DEPART && occupied != 5'd0 && $urandom_range(0, 9) < 7)
        begin
            j = w.slot_index;
            while (wait_state[j] == SLOT_FREE)
                j = (j + 1) % NUM_SLOTS;
            w.slot_index = 4'(j);
        end
        if (w.req_type != REQ_ADD && $urandom_range(0, 3) == 0)
            w.reason = wake_all_code;
        return w;
    endfunction

    // receiver: quiet stretches, random stalls, and long stall runs
    initial
    begin
        int mode;
        int span;
        int run_left;
        out_stall = 1'b0;
        run_left  = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 250);
            repeat (span)
            begin
                @(negedge clk);
                if (mode == 0)
                    out_stall = 1'b0;
                else if (mode == 1)
                    out_stall = $urandom_range(0, 9) < 3;
                else if (run_left == 0)
                begin
                    out_stall = ~out_stall;
                    run_left  = out_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                else
                    run_left = run_left - 1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        wsrt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected result word: %p", out_data);
                mismatch_cnt = mismatch_cnt + 1;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.status !== want.status || out_data.slot_out !== want.slot_out ||
                    out_data.woken_mask !== want.woken_mask ||
                    out_data.was_released !== want.was_released ||
                    out_data.active_count !== want.active_count)
                begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected st=%0d slot=%0d mask=%h was=%0d cnt=%0d, got st=%0d slot=%0d mask=%h was=%0d cnt=%0d",
                                 want.status, want.slot_out, want.woken_mask,
                                 want.was_released, want.active_count,
                                 out_data.status, out_data.slot_out, out_data.woken_mask,
                                 out_data.was_released, out_data.active_count);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t  row;
        wsrt_in_t  w;
        wsrt_out_t fixed;
        int        profile;
        int        sent;
        int        burst;
        int        gap;
        bit        quiet;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        occupied     = 5'd0;
        wake_all_code = 16'hFFFF;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            wait_state[i]  = SLOT_FREE;
            wait_reason[i] = 16'h0000;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        reg_write(3'(4 * REG_ALL_REASON), 32'h0000_FFFF);
        for (int k = 0; k < $size(DIRECTED); k++)
        begin
            row = DIRECTED[k];
            w.req_type   = row.kind;
            w.reason     = row.rsn;
            w.slot_index = row.idx;
            fixed.status       = row.st;
            fixed.slot_out     = row.slot;
            fixed.woken_mask   = row.mask;
            fixed.was_released = row.was;
            fixed.active_count = row.cnt;
            send_word(w, row.typed, fixed);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            for (int i = 0; i < 4; i++)
                reason_pool[i] = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
            if (p == 0)
                reg_write(3'(4 * REG_ALL_REASON), 32'h0000_0000);
            else if (p == 1)
                reg_write(3'(4 * REG_ALL_REASON), 32'h0000_FFFF);
            else
                reg_write(3'(4 * REG_ALL_REASON),
                          {16'h0, $urandom_range(0, 1) ? reason_pool[$urandom_range(0, 3)]
                                                       : 16'($urandom)});
            profile = (p % 3 == 2) ? PROF_DRAIN : (p % 3 == 0) ? PROF_FILL : PROF_MIXED;
            quiet   = $urandom_range(0, 3) == 0;
            sent    = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 8);
                gap   = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                repeat (burst)
                begin
                    send_word(random_word(profile), 1'b0, '0);
                    sent = sent + 1;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (awaited_results.size() != 0)
            mismatch_cnt = mismatch_cnt + awaited_results.size();
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
